// File: rtl/core/assert_macros.svh
// assertion macros shared by the deframer checker
// clocked on clk_i, reset by rst_ni of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/bsd_pkg.sv
// types and constants of the byte-stuffed frame deframer
// no dependencies
package bsd_pkg;

  localparam int unsigned MaxFrameDefault = 256;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7F;
  localparam logic [7:0] EscFlag  = 8'h80;
  localparam logic [7:0] EscEsc   = 8'h81;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_DATA = 2'd1,
    MODE_ESC  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [8:0] frame_length;
    logic [7:0] sum_without_last;
    logic [7:0] final_byte;
  } out_item_t;

  // one decoded step handed to the result register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

// File: rtl/core/bsd_chan_if.sv
// valid/ready channel carrying one item per handshake
// payload type comes from bsd_pkg at the instantiation
interface bsd_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/bsd_in_reg.sv
// input register of the deframer: holds one received byte until decoded
// uses bsd_pkg
module bsd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  bsd_pkg::in_item_t item_i,
  output logic             ready_o,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [7:0]       byte_o
);
  import bsd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // free slot, or the held byte moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= item_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

// File: rtl/core/bsd_decode.sv
// framing state machine: unstuffing, length and sum tracking, result build
// uses bsd_pkg
module bsd_decode #(
  parameter int unsigned MaxFrame = bsd_pkg::MaxFrameDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output bsd_pkg::step_res_t res_o
);
  import bsd_pkg::*;

  localparam logic [8:0] MaxCount = 9'(MaxFrame);

  mode_e      mode_q, mode_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] prev_q, prev_d;

  logic       take;
  logic [7:0] pb;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    prev_d = prev_q;
    take   = 1'b0;
    pb     = byte_i;
    res_o  = '0;

    unique case (mode_q)
      MODE_DATA: begin
        if (byte_i == FlagByte) begin
          // flags before any payload are ignored
          if (cnt_q != 9'd0) begin
            mode_d                      = MODE_HUNT;
            res_o.valid                 = 1'b1;
            res_o.item.kind             = KIND_CLOSE;
            res_o.item.frame_length     = cnt_q;
            res_o.item.sum_without_last = sum_q - prev_q;
            res_o.item.final_byte       = prev_q;
          end
        end else if (byte_i == EscByte) begin
          mode_d = MODE_ESC;
        end else begin
          take = 1'b1;
        end
      end
      MODE_ESC: begin
        if (byte_i == EscFlag) begin
          take = 1'b1;
          pb   = FlagByte;
        end else if (byte_i == EscEsc) begin
          take = 1'b1;
          pb   = EscByte;
        end else begin
          mode_d          = MODE_HUNT;
          res_o.valid     = 1'b1;
          res_o.item.kind = KIND_DISCARD;
        end
      end
      default: begin
        mode_d = MODE_HUNT;
        if (byte_i == FlagByte) begin
          mode_d = MODE_DATA;
          cnt_d  = '0;
          sum_d  = '0;
          prev_d = '0;
        end
      end
    endcase

    if (take) begin
      res_o.valid = 1'b1;
      if (cnt_q >= MaxCount) begin
        // overflow drops the frame, the byte is not reported
        mode_d          = MODE_HUNT;
        res_o.item.kind = KIND_DISCARD;
      end else begin
        mode_d                  = MODE_DATA;
        cnt_d                   = cnt_q + 9'd1;
        sum_d                   = sum_q + pb;
        prev_d                  = pb;
        res_o.item.kind         = KIND_PAYLOAD;
        res_o.item.payload_byte = pb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      cnt_q  <= '0;
      sum_q  <= '0;
      prev_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      prev_q <= prev_d;
    end
  end
endmodule

// File: rtl/core/bsd_out_reg.sv
// result register of the deframer, drives the result channel
// uses bsd_pkg
module bsd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bsd_pkg::step_res_t res_i,
  input  logic               ready_i,
  output logic               valid_o,
  output bsd_pkg::out_item_t item_o
);
  import bsd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.valid;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// File: rtl/core/byte_stuffed_frame_deframer_top.sv
// top level of the byte-stuffed frame deframer
// uses bsd_pkg, bsd_chan_if, bsd_in_reg, bsd_decode, bsd_out_reg
//
// Takes one raw serial byte per item, hunts for an opening 0x7E flag, removes
// 0x7F escapes (0x80 gives 0x7E, 0x81 gives 0x7F) and gives zero or one result
// per byte: a payload byte at once, a close result with length, the mod-256
// sum of all bytes but the last and the last byte, or a discard on a bad
// escape or when a frame grows past MaxFrame bytes. A byte is accepted every
// cycle while results are taken; the byte sits in the input register after
// the accepting edge and its result is shown once the decode stage loads the
// result register. The input stalls only while the result register holds an
// item that has not been taken.
module byte_stuffed_frame_deframer_top #(
  parameter int unsigned MaxFrame = bsd_pkg::MaxFrameDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsd_chan_if.sink          rx_ch_i,
  bsd_chan_if.source        res_ch_o
);
  import bsd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  step_res_t  step_res;

  // decode whenever a byte waits and the result slot is free or draining
  assign advance = in_valid && (!res_ch_o.valid || res_ch_o.ready);

  bsd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_ch_i.valid),
    .item_i    (rx_ch_i.payload),
    .ready_o   (rx_ch_i.ready),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  bsd_decode #(
    .MaxFrame (MaxFrame)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte),
    .res_o  (step_res)
  );

  bsd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .ready_i (res_ch_o.ready),
    .valid_o (res_ch_o.valid),
    .item_o  (res_ch_o.payload)
  );
endmodule

// File: rtl/core/bsd_checker.sv
// port-level checks of the deframer, bound to the top level
// uses bsd_pkg and assert_macros.svh
`include "assert_macros.svh"

module bsd_checker #(
  parameter int unsigned MaxFrame = bsd_pkg::MaxFrameDefault
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input bsd_pkg::out_item_t res_item_i
);
  import bsd_pkg::*;

  localparam logic [8:0] MaxCount = 9'(MaxFrame);

  `BSD_ASSERT_ALWAYS(a_no_res_in_reset, !rst_ni |-> !res_valid_i, "result valid during reset")

  `BSD_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_item_i), "stalled result changed")

  `BSD_ASSERT(a_kind_legal, res_valid_i |-> res_item_i.kind != 2'd3, "unused result kind")

  `BSD_ASSERT(a_payload_clean, res_valid_i && res_item_i.kind == KIND_PAYLOAD |-> res_item_i.frame_length == 9'd0 && res_item_i.final_byte == 8'd0, "payload item carries close fields")

  `BSD_ASSERT(a_close_len, res_valid_i && res_item_i.kind == KIND_CLOSE |-> res_item_i.frame_length != 9'd0 && res_item_i.frame_length <= MaxCount, "closed frame length out of range")
endmodule

bind byte_stuffed_frame_deframer_top bsd_checker #(
  .MaxFrame (MaxFrame)
) u_bsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_ch_o.valid),
  .res_ready_i (res_ch_o.ready),
  .res_item_i  (res_ch_o.payload)
);

// File: tb/byte_stuffed_frame_deframer_top_tb.sv
// testbench of the byte-stuffed frame deframer: a directed part, the frame length limit and
// random traffic, each result checked against a predictor of the deframer inside this file
// depends on bsd_pkg, bsd_chan_if and byte_stuffed_frame_deframer_top
`timescale 1ns / 100ps

module byte_stuffed_frame_deframer_top_tb;
  import bsd_pkg::*;

  localparam int unsigned MAX_LEN = MaxFrameDefault;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  bsd_chan_if #(.item_t(in_item_t))  rx_ch ();
  bsd_chan_if #(.item_t(out_item_t)) res_ch ();

  byte_stuffed_frame_deframer_top #(.MaxFrame(MAX_LEN)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_ch_i  (rx_ch),
    .res_ch_o (res_ch)
  );

  // predictor state
  mode_e      frame_mode;
  logic [8:0] frame_count;
  logic [7:0] frame_sum;
  logic [7:0] frame_last;

  out_item_t pending_results[$];

  int  bytes_sent;
  int  mismatches;
  int  payload_seen;
  int  close_seen;
  int  discard_seen;
  int  idle_cycles;
  bit  src_idle;
  bit  sink_idle;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // works out the result of one accepted byte and queues it
  task automatic deframe_byte(input logic [7:0] b);
    out_item_t  r;
    logic [7:0] dec;
    bit         take;
    bit         drop;
    r = '0;
    dec = '0;
    take = 1'b0;
    drop = 1'b0;
    case (frame_mode)
      MODE_DATA: begin
        if (b == FlagByte) begin
          // flags before any payload keep the frame open
          if (frame_count != 0) begin
            frame_mode = MODE_HUNT;
            r.kind = KIND_CLOSE;
            r.frame_length = frame_count;
            r.sum_without_last = frame_sum - frame_last;
            r.final_byte = frame_last;
            pending_results.push_back(r);
          end
        end else if (b == EscByte) begin
          frame_mode = MODE_ESC;
        end else begin
          take = 1'b1;
          dec = b;
        end
      end
      MODE_ESC: begin
        if (b == EscFlag) begin
          take = 1'b1;
          dec = FlagByte;
        end else if (b == EscEsc) begin
          take = 1'b1;
          dec = EscByte;
        end else begin
          drop = 1'b1;
        end
      end
      default: begin
        frame_mode = MODE_HUNT;
        if (b == FlagByte) begin
          frame_mode = MODE_DATA;
          frame_count = '0;
          frame_sum = '0;
          frame_last = '0;
        end
      end
    endcase
    if (take) begin
      if (frame_count >= MAX_LEN) begin
        drop = 1'b1;
      end else begin
        frame_count = frame_count + 9'd1;
        frame_sum = frame_sum + dec;
        frame_last = dec;
        frame_mode = MODE_DATA;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = dec;
        pending_results.push_back(r);
      end
    end
    if (drop) begin
      frame_mode = MODE_HUNT;
      r = '0;
      r.kind = KIND_DISCARD;
      pending_results.push_back(r);
    end
  endtask

  // input side: returns at the edge where the item is accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.payload <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_escaped(input logic [7:0] b);
    if (b == FlagByte) begin
      send_byte(EscByte);
      send_byte(EscFlag);
    end else if (b == EscByte) begin
      send_byte(EscByte);
      send_byte(EscEsc);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic test_hunt_and_flags();
    // noise while hunting, repeated opening flags, a three byte frame,
    // a stray byte after close and a single byte frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(EscByte);
    send_byte(FlagByte);
    send_byte(FlagByte);
    send_byte(FlagByte);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(FlagByte);
    send_byte(8'h5A);
    send_byte(FlagByte);
    send_byte(8'h3C);
    send_byte(FlagByte);
  endtask

  task automatic test_escapes();
    send_byte(FlagByte);
    send_byte(EscByte);
    send_byte(EscFlag);
    send_byte(EscByte);
    send_byte(EscEsc);
    send_byte(FlagByte);
  endtask

  task automatic test_bad_escapes();
    // flag right after an escape, then escape after escape
    send_byte(FlagByte);
    send_byte(8'h11);
    send_byte(EscByte);
    send_byte(FlagByte);
    send_byte(FlagByte);
    send_byte(EscByte);
    send_byte(EscByte);
  endtask

  task automatic test_frame_limit();
    logic [7:0] b;
    // a frame of exactly the maximum length, then one byte more
    send_byte(FlagByte);
    for (int i = 0; i < MAX_LEN; i++) begin
      b = i[7:0];
      send_escaped(b);
    end
    send_byte(FlagByte);
    send_byte(FlagByte);
    for (int i = 0; i <= MAX_LEN; i++) begin
      b = 8'($urandom_range(0, 255));
      send_escaped(b);
    end
    send_byte(FlagByte);
  endtask

  task automatic send_random_frame(input int len, input bit corrupt);
    logic [7:0] b;
    int         bad_at;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if (b == FlagByte) b = ~b;
      send_byte(b);
    end
    repeat ($urandom_range(1, 2)) send_byte(FlagByte);
    bad_at = corrupt ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) begin
        // broken escape aborts the frame, the rest is not sent
        send_byte(EscByte);
        b = 8'($urandom_range(0, 255));
        if (b == EscFlag || b == EscEsc) b = $urandom_range(0, 1) ? FlagByte : EscByte;
        send_byte(b);
        return;
      end
      case ($urandom_range(0, 7))
        0: b = FlagByte;
        1: b = EscByte;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_escaped(b);
    end
    send_byte(FlagByte);
  endtask

  task automatic test_random_traffic();
    int start;
    int len;
    int choice;
    logic [7:0] b;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        // raw bytes heavy in control codes
        repeat ($urandom_range(5, 20)) begin
          case ($urandom_range(0, 5))
            0: b = FlagByte;
            1: b = EscByte;
            2: b = EscFlag;
            3: b = EscEsc;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b);
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
        send_random_frame(len, choice == 1);
      end
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // result side: random stall before each item while sink_idle is set
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.payload.rx_byte);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      case (got.kind)
        KIND_PAYLOAD: payload_seen++;
        KIND_CLOSE:   close_seen++;
        default:      discard_seen++;
      endcase
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: kind %0d", got.kind);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.frame_length !== want.frame_length ||
            got.sum_without_last !== want.sum_without_last ||
            got.final_byte !== want.final_byte) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: got kind %0d byte %02h len %0d sum %02h last %02h",
                     $realtime, got.kind, got.payload_byte, got.frame_length,
                     got.sum_without_last, got.final_byte);
            $display("             want kind %0d byte %02h len %0d sum %02h last %02h",
                     want.kind, want.payload_byte, want.frame_length,
                     want.sum_without_last, want.final_byte);
          end
        end
      end
    end
  end

  // counts cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int guard;
    frame_mode = MODE_HUNT;
    frame_count = '0;
    frame_sum = '0;
    frame_last = '0;
    bytes_sent = 0;
    mismatches = 0;
    payload_seen = 0;
    close_seen = 0;
    discard_seen = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    rst_ni <= 1'b0;
    rx_ch.valid <= 1'b0;
    rx_ch.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunt_and_flags();
    test_escapes();
    test_bad_escapes();
    test_frame_limit();
    test_random_traffic();
    rx_ch.valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("%0d bytes sent; %0d payload bytes, %0d closed frames, %0d discards checked",
             bytes_sent, payload_seen, close_seen, discard_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
